@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// shared widths, codes and controller/datapath command and status types
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int ID_W    = 12;
    localparam int TICKS_W = 20;

    typedef enum logic {
        MODE_SLEEP = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    typedef enum logic {
        STATUS_WOKEN    = 1'b0,
        STATUS_REJECTED = 1'b1
    } t_status;

    typedef struct packed {
        logic append;
        logic reject;
        logic start;
        logic rd;
        logic eval;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic rd_more;
        logic wake;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/sct_in_if.sv @@
// ----------------------------------------------------------------------------
// sct_in_if
// request channel: sleep or tick items with valid/ready handshake
// ----------------------------------------------------------------------------
interface sct_in_if
    import sct_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [ID_W-1:0]    thread_id;
    logic [TICKS_W-1:0] sleep_ticks;

    modport source (output valid, mode, thread_id, sleep_ticks, input ready);
    modport sink   (input valid, mode, thread_id, sleep_ticks, output ready);
endinterface

@@ rtl/sct_out_if.sv @@
// ----------------------------------------------------------------------------
// sct_out_if
// result channel: woken or rejected thread ids with valid/ready handshake
// ----------------------------------------------------------------------------
interface sct_out_if
    import sct_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] woken_id;
    logic            status;
    logic            last;

    modport source (output valid, woken_id, status, last, input ready);
    modport sink   (input valid, woken_id, status, last, output ready);
endinterface

@@ rtl/sct_datapath.sv @@
// ----------------------------------------------------------------------------
// sct_datapath
// entry memories, occupancy and walk counters, pending result and output reg
// ----------------------------------------------------------------------------
module sct_datapath
    import sct_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [ID_W-1:0]    i_thread_id,
    input  logic [TICKS_W-1:0] i_sleep_ticks,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [ID_W-1:0]    o_woken_id,
    output logic               o_status,
    output logic               o_last
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [ID_W-1:0]    mem_id  [SLOTS];
    logic [TICKS_W-1:0] mem_rem [SLOTS];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_keep;
    logic [CW-1:0]      r_rd_idx;
    logic [ID_W-1:0]    r_rd_id;
    logic [TICKS_W-1:0] r_rd_rem;
    logic               r_pend_valid;
    logic [ID_W-1:0]    r_pend_id;
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic               r_out_status;
    logic               r_out_last;

    logic               wake;
    logic               out_free;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [ID_W-1:0]    wid;
    logic [TICKS_W-1:0] wrem;
    logic               out_load;
    logic [ID_W-1:0]    n_out_id;
    logic               n_out_status;
    logic               n_out_last;

    assign wake     = (r_rd_rem <= TICKS_W'(1));
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.full       = (r_count == CW'(SLOTS));
    assign o_sts.rd_more    = (r_rd_idx < r_count);
    assign o_sts.wake       = wake;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    // memory write: append at the tail, or compact a surviving entry
    always_comb begin
        we    = i_cmd.append || (i_cmd.eval && !wake);
        waddr = i_cmd.append ? r_count[AW-1:0] : r_keep[AW-1:0];
        wid   = i_cmd.append ? i_thread_id : r_rd_id;
        wrem  = i_cmd.append ? i_sleep_ticks : (r_rd_rem - TICKS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_id[waddr]  <= wid;
            mem_rem[waddr] <= wrem;
        end
        if (i_cmd.rd) begin
            r_rd_id  <= mem_id[r_rd_idx[AW-1:0]];
            r_rd_rem <= mem_rem[r_rd_idx[AW-1:0]];
        end
    end

    // output register load
    always_comb begin
        out_load     = 1'b0;
        n_out_id     = r_pend_id;
        n_out_status = STATUS_WOKEN;
        n_out_last   = 1'b0;
        if (i_cmd.reject) begin
            out_load     = 1'b1;
            n_out_id     = i_thread_id;
            n_out_status = STATUS_REJECTED;
            n_out_last   = 1'b1;
        end else if (i_cmd.eval && wake && r_pend_valid) begin
            out_load = 1'b1;
        end else if (i_cmd.finish && r_pend_valid) begin
            out_load   = 1'b1;
            n_out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_keep       <= '0;
            r_rd_idx     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.start) begin
                r_keep       <= '0;
                r_rd_idx     <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (i_cmd.eval) begin
                if (wake) begin
                    r_pend_valid <= 1'b1;
                end else begin
                    r_keep <= r_keep + CW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_count      <= r_keep;
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && wake) begin
            r_pend_id <= r_rd_id;
        end
        if (out_load) begin
            r_out_id     <= n_out_id;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_woken_id  = r_out_id;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("occupancy above table size");

    a_keep_behind_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keep <= r_rd_idx)
        else $error("compaction pointer ahead of read pointer");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not grow the table");

    a_no_lost_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over an untaken one");

endmodule

@@ rtl/sct_ctrl.sv @@
// ----------------------------------------------------------------------------
// sct_ctrl
// controller: accepts items, sequences the tick walk and the final flush
// ----------------------------------------------------------------------------
module sct_ctrl
    import sct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_mode,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    t_state r_state;
    logic   r_eval_valid;
    logic   accept;
    logic   stall;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign stall      = r_eval_valid && i_sts.wake && i_sts.pend_valid && !i_sts.out_free;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_TICK) begin
                        o_cmd.start = 1'b1;
                    end else if (i_sts.full) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (!stall) begin
                    o_cmd.eval = r_eval_valid;
                    o_cmd.rd   = i_sts.rd_more;
                end
            end
            S_DRAIN: begin
                o_cmd.finish = !i_sts.pend_valid || i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_eval_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_mode == MODE_TICK) begin
                        r_state      <= S_WALK;
                        r_eval_valid <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (!stall) begin
                        r_eval_valid <= i_sts.rd_more;
                        if (!i_sts.rd_more) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (o_cmd.finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_eval_only_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval |-> r_state == S_WALK && r_eval_valid)
        else $error("evaluation outside the walk");

    a_drain_follows_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && !stall && !i_sts.rd_more |=> r_state == S_DRAIN)
        else $error("walk end did not lead to drain");

    a_tick_starts_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_WALK && !r_eval_valid)
        else $error("tick did not start a walk");

endmodule

@@ rtl/sleep_countdown_table.sv @@
// ----------------------------------------------------------------------------
// sleep_countdown_table
// table of sleeping thread ids, counted down by timer ticks
//
// i_in carries items: mode 0 appends thread_id with sleep_ticks (0 acts as
// 1), mode 1 is one timer tick. o_out carries results: woken_id, status
// (0 woken, 1 sleep rejected on a full table) and last on the final result
// of an item.
// A sleep on a free slot is appended when accepted; a rejected sleep shows
// its result the next cycle. A tick walks the occupied slots through one
// memory read port, one slot a cycle while results are taken, and no new
// item is taken until the walk and its flush end; woken ids leave in table
// order with one result of delay, the last flushed at the end of the walk.
// Reset (synchronous, active low) empties the table; memory contents stay
// undefined and are never read above the occupancy.
// When the receiver stalls, the single output register holds its result,
// the walk pauses on the next woken entry and i_in.ready stays low.
// ----------------------------------------------------------------------------
module sleep_countdown_table
    import sct_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sct_in_if.sink    i_in,
    sct_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    sct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (i_in.mode),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_thread_id   (i_in.thread_id),
        .i_sleep_ticks (i_in.sleep_ticks),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_woken_id    (o_out.woken_id),
        .o_status      (o_out.status),
        .o_last        (o_out.last)
    );

endmodule

@@ sim/sleep_countdown_table_checker.sv @@
// ----------------------------------------------------------------------------
// sleep_countdown_table_checker
// watches both channels of the sleep countdown table, keeps its own copy of
// the sleeper table, predicts the woken and rejected ids of every accepted
// item and compares each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module sleep_countdown_table_checker
    import sct_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sct_in_if    in_ch,
    sct_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [ID_W-1:0] woken_id;
        t_status         status;
        logic            last;
    } t_wake_result;

    t_wake_result       wake_queue[$];
    logic [ID_W-1:0]    sleeper_id   [SLOTS];
    logic [TICKS_W-1:0] sleeper_left [SLOTS];
    int                 sleeper_count;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        sleeper_count = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        o_fail_count++;
    endtask

    function automatic void predict_item(t_mode mode, logic [ID_W-1:0] id,
                                         logic [TICKS_W-1:0] ticks);
        t_wake_result w;
        int           keep;
        int           first_new;
        keep      = 0;
        first_new = wake_queue.size();
        if (mode == MODE_SLEEP) begin
            if (sleeper_count >= SLOTS) begin
                w.woken_id = id;
                w.status   = STATUS_REJECTED;
                w.last     = 1'b1;
                wake_queue.push_back(w);
            end else begin
                sleeper_id[sleeper_count]   = id;
                sleeper_left[sleeper_count] = ticks;
                sleeper_count++;
            end
        end else begin
            for (int i = 0; i < sleeper_count; i++) begin
                if (sleeper_left[i] <= 1) begin
                    w.woken_id = sleeper_id[i];
                    w.status   = STATUS_WOKEN;
                    w.last     = 1'b0;
                    wake_queue.push_back(w);
                end else begin
                    sleeper_id[keep]   = sleeper_id[i];
                    sleeper_left[keep] = sleeper_left[i] - 1'b1;
                    keep++;
                end
            end
            sleeper_count = keep;
            if (wake_queue.size() > first_new) begin
                w      = wake_queue.pop_back();
                w.last = 1'b1;
                wake_queue.push_back(w);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_wake_result want;
        if (!i_rst_n) begin
            sleeper_count = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(t_mode'(in_ch.mode), in_ch.thread_id, in_ch.sleep_ticks);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (wake_queue.size() == 0) begin
                    report_mismatch("unexpected result, id", 32'(0), 32'(out_ch.woken_id));
                end else begin
                    want = wake_queue.pop_front();
                    if (out_ch.woken_id !== want.woken_id)
                        report_mismatch("woken_id", 32'(want.woken_id),
                                        32'(out_ch.woken_id));
                    if (out_ch.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(out_ch.status));
                    if (out_ch.last !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(out_ch.last));
                end
            end
        end
        o_pending = wake_queue.size();
    end

endmodule

@@ sim/sleep_countdown_table_tb.sv @@
// ----------------------------------------------------------------------------
// sleep_countdown_table_tb
// drives sleep and tick items into the sleep countdown table: a directed
// opening (empty-table tick, zero and one counts, repeated ids, full table,
// sixteen wakes in one tick, maximum count), then random sleeps and ticks
// under changing idle patterns and one long result stall
// ----------------------------------------------------------------------------
module sleep_countdown_table_tb
    import sct_pkg::*;
;

    localparam int SLOTS = 16;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   phase;
    logic hold_rx;
    int   fail_count;
    int   pending;

    sct_in_if  in_if();
    sct_out_if out_if();

    sleep_countdown_table #(.SLOTS(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sleep_countdown_table_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_if),
        .out_ch       (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("** sleep_countdown_table: FAILED **");
        $finish;
    end

    // receiver side
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long result stall so input backs up
    initial begin
        hold_rx = 1'b0;
        wait (phase == 3);
        repeat (4) @(negedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_rx <= 1'b0;
    end

    task automatic send_request(t_mode mode, logic [ID_W-1:0] id,
                                logic [TICKS_W-1:0] ticks);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.mode        <= mode;
        in_if.thread_id   <= id;
        in_if.sleep_ticks <= ticks;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [TICKS_W-1:0] ticks;
        if ($urandom_range(0, 39) == 0)
            ticks = TICKS_W'($urandom);
        else
            ticks = TICKS_W'($urandom_range(0, 6));
        if ($urandom_range(0, 99) < 35)
            send_request(MODE_TICK, ID_W'($urandom), TICKS_W'($urandom));
        else
            send_request(MODE_SLEEP, ID_W'($urandom), ticks);
    endtask

    initial begin
        int waited;
        in_if.valid       = 1'b0;
        in_if.mode        = MODE_SLEEP;
        in_if.thread_id   = '0;
        in_if.sleep_ticks = '0;
        tx_idle_pct       = 21;
        rx_idle_pct       = 73;
        phase             = 0;
        waited            = 0;
        i_rst_n           = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening
        send_request(MODE_TICK, 12'hfff, '1);
        send_request(MODE_SLEEP, 12'h000, 20'd0);
        send_request(MODE_SLEEP, 12'hfff, 20'd1);
        send_request(MODE_SLEEP, 12'hfff, 20'd2);
        send_request(MODE_TICK, 12'h000, '0);
        for (int k = 0; k < 15; k++) begin
            send_request(MODE_SLEEP, ID_W'($urandom), TICKS_W'($urandom_range(0, 1)));
        end
        send_request(MODE_SLEEP, 12'ha5a, 20'd3);
        send_request(MODE_TICK, ID_W'($urandom), TICKS_W'($urandom));
        send_request(MODE_SLEEP, 12'h5a5, 20'hfffff);
        send_request(MODE_TICK, ID_W'($urandom), TICKS_W'($urandom));

        // random part in three idle patterns
        phase = 1;
        for (int n = 0; n < 32; n++) send_random_item();
        tx_idle_pct <= 73;
        rx_idle_pct <= 21;
        phase = 2;
        for (int n = 0; n < 32; n++) send_random_item();
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        phase = 3;
        for (int n = 0; n < 32; n++) send_random_item();
        in_if.valid <= 1'b0;

        while (pending != 0 && waited < 50000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SLOTS + 8) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("** sleep_countdown_table: PASSED **");
        end else begin
            $display("** sleep_countdown_table: FAILED **");
        end
        $finish;
    end

endmodule
